@@ hw/rtl/orfd_pkg.sv @@
package orfd_pkg;

    // Frame layout: code bits, then group, on/off, two channel and two unit bits.
    localparam int CODE_BITS  = 26;
    localparam int FRAME_BITS = CODE_BITS + 6;
    localparam int CNT_W      = 6;
    localparam int CODE_W     = 26;
    localparam int CFG_W      = 26;
    localparam int NS_W       = 32;

    // Pulse thresholds in nanoseconds. The gap is quantised to whole units and
    // saturated at 255 units, but every threshold lies well below saturation,
    // so a compare on the raw gap gives the same answer as one on the units.
    localparam logic [NS_W-1:0] UNIT_NS       = 32'd250000;
    localparam logic [NS_W-1:0] SYNC_MIN_NS   = 32'd10 * UNIT_NS;
    localparam logic [NS_W-1:0] ONE_MAX_NS    = 32'd5 * UNIT_NS;
    localparam logic [NS_W-1:0] PAUSE_MIN_NS  = 32'd40 * UNIT_NS;

    // Burst phase codes.
    localparam logic [2:0] PH_SYNC  = 3'd0;
    localparam logic [2:0] PH_BITS  = 3'd1;
    localparam logic [2:0] PH_PAUSE = 3'd2;
    localparam logic [2:0] PH_DONE  = 3'd3;
    localparam logic [2:0] PH_ERR   = 3'd4;

    typedef logic [2:0] status_t;

    // Frame status codes.
    localparam status_t ST_OK       = 3'd0;
    localparam status_t ST_NO_SYNC  = 3'd1;
    localparam status_t ST_BAD_PAIR = 3'd2;
    localparam status_t ST_NO_PAUSE = 3'd3;
    localparam status_t ST_SHORT    = 3'd4;

    // Localparam register indexes.
    localparam logic CFG_FILTER_ENABLE = 1'b0;
    localparam logic CFG_FILTER_CODE   = 1'b1;

    typedef struct packed {
        status_t             status;
        logic [CODE_W-1:0]   tx_code;
        logic                group_flag;
        logic                switch_on;
        logic [1:0]          chan_sel;
        logic [1:0]          unit_sel;
        logic                filter_match;
    } frame_result_t;

endpackage

@@ hw/rtl/orfd_pulse_if.sv @@
interface orfd_pulse_if;
    import orfd_pkg::*;

    logic            valid;
    logic            ready;
    logic [NS_W-1:0] low_time_ns;
    logic            last_pulse;

    modport source (output valid, output low_time_ns, output last_pulse, input ready);
    modport sink   (input valid, input low_time_ns, input last_pulse, output ready);
endinterface

@@ hw/rtl/orfd_frame_if.sv @@
interface orfd_frame_if;
    import orfd_pkg::*;

    logic              valid;
    logic              ready;
    status_t           status;
    logic [CODE_W-1:0] tx_code;
    logic              group_flag;
    logic              switch_on;
    logic [1:0]        chan_sel;
    logic [1:0]        unit_sel;
    logic              filter_match;

    modport source (output valid, output status, output tx_code,
                    output group_flag, output switch_on, output chan_sel,
                    output unit_sel, output filter_match, input ready);
    modport sink   (input valid, input status, input tx_code,
                    input group_flag, input switch_on, input chan_sel,
                    input unit_sel, input filter_match, output ready);
endinterface

@@ hw/rtl/orfd_burst.sv @@
module orfd_burst (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [orfd_pkg::NS_W-1:0]   low_time_ns,
    input  logic                        last_pulse,
    input  logic                        filter_enable,
    input  logic [orfd_pkg::CODE_W-1:0] filter_code,
    output orfd_pkg::frame_result_t     result
);
    import orfd_pkg::*;

    logic [2:0]            phase_reg, phase_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  first_half_reg, first_half_next;
    logic                  held_reg, held_next;
    logic [FRAME_BITS-1:0] frame_reg, frame_next;
    status_t               err_reg, err_next;

    // State after the current pulse, before any end-of-burst clear.
    logic [2:0]            ph_a;
    logic [CNT_W-1:0]      cnt_a;
    logic                  fh_a;
    logic                  held_a;
    logic [FRAME_BITS-1:0] fb_a;
    status_t               err_a;

    logic                  sync_ok;
    logic                  phys_bit;
    logic                  pause_ok;
    logic [CNT_W-1:0]      cnt_inc;
    logic [CODE_W-1:0]     code_w;

    // Pulse classification by gap length.
    assign sync_ok  = (low_time_ns >= SYNC_MIN_NS);
    assign phys_bit = (low_time_ns <  ONE_MAX_NS);
    assign pause_ok = (low_time_ns >= PAUSE_MIN_NS);
    assign cnt_inc  = count_reg + CNT_W'(1);

    // Advance the burst by one pulse.
    always_comb
    begin
        ph_a   = phase_reg;
        cnt_a  = count_reg;
        fh_a   = first_half_reg;
        held_a = held_reg;
        fb_a   = frame_reg;
        err_a  = err_reg;
        case (phase_reg)
            PH_SYNC:
            begin
                if (sync_ok)
                begin
                    ph_a = PH_BITS;
                end
                else
                begin
                    ph_a  = PH_ERR;
                    err_a = ST_NO_SYNC;
                end
            end
            PH_BITS:
            begin
                if (!first_half_reg)
                begin
                    held_a = phys_bit;
                    fh_a   = 1'b1;
                end
                else
                begin
                    fh_a = 1'b0;
                    if (held_reg == phys_bit)
                    begin
                        ph_a  = PH_ERR;
                        err_a = ST_BAD_PAIR;
                    end
                    else
                    begin
                        if (held_reg && (count_reg < CNT_W'(FRAME_BITS)))
                        begin
                            fb_a[count_reg[$clog2(FRAME_BITS)-1:0]] = 1'b1;
                        end
                        cnt_a = cnt_inc;
                        if (cnt_inc >= CNT_W'(FRAME_BITS))
                        begin
                            ph_a = PH_PAUSE;
                        end
                    end
                end
            end
            PH_PAUSE:
            begin
                if (pause_ok)
                begin
                    ph_a = PH_DONE;
                end
                else
                begin
                    ph_a  = PH_ERR;
                    err_a = ST_NO_PAUSE;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Result word for a last pulse, built from the advanced state.
    assign code_w = CODE_W'(fb_a[CODE_BITS-1:0]);

    always_comb
    begin
        result = '0;
        case (ph_a)
            PH_ERR:   result.status = err_a;
            PH_DONE:  result.status = ST_OK;
            PH_PAUSE: result.status = ST_NO_PAUSE;
            default:  result.status = ST_SHORT;
        endcase
        if (ph_a == PH_DONE)
        begin
            result.tx_code      = code_w;
            result.group_flag   = ~fb_a[CODE_BITS];
            result.switch_on    = ~fb_a[CODE_BITS+1];
            result.chan_sel     = fb_a[CODE_BITS+3:CODE_BITS+2];
            result.unit_sel     = fb_a[CODE_BITS+5:CODE_BITS+4];
            result.filter_match = !filter_enable || (code_w == filter_code);
        end
    end

    // The last pulse of a burst clears the state for the next burst.
    always_comb
    begin
        phase_next      = phase_reg;
        count_next      = count_reg;
        first_half_next = first_half_reg;
        held_next       = held_reg;
        frame_next      = frame_reg;
        err_next        = err_reg;
        if (step)
        begin
            if (last_pulse)
            begin
                phase_next      = PH_SYNC;
                count_next      = '0;
                first_half_next = 1'b0;
                held_next       = 1'b0;
                frame_next      = '0;
                err_next        = ST_OK;
            end
            else
            begin
                phase_next      = ph_a;
                count_next      = cnt_a;
                first_half_next = fh_a;
                held_next       = held_a;
                frame_next      = fb_a;
                err_next        = err_a;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SYNC;
            count_reg      <= '0;
            first_half_reg <= 1'b0;
            held_reg       <= 1'b0;
            frame_reg      <= '0;
            err_reg        <= ST_OK;
        end
        else
        begin
            phase_reg      <= phase_next;
            count_reg      <= count_next;
            first_half_reg <= first_half_next;
            held_reg       <= held_next;
            frame_reg      <= frame_next;
            err_reg        <= err_next;
        end
    end

endmodule

@@ hw/rtl/ook_remote_frame_decoder.sv @@
// Pulse-distance OOK remote frame decoder.
// The pulse channel takes one word per radio pulse: the low gap after the
// pulse in nanoseconds and a flag on the final pulse of the burst. The frame
// channel gives one word per burst, on its final pulse: status, transmitter
// code, group and on/off flags, channel and unit bits, and the filter match.
// A pulse is accepted when valid and ready are both high. One pulse can be
// taken in every cycle while ready is high: each word is registered, then
// classified and folded into the burst state, and a frame word enters the
// output register when its final pulse leaves the input register.
// The output register parts the two sides: pulses that end no burst keep
// flowing while a frame word waits. Only when a final pulse is held in the
// input register and the previous frame word has not been taken does ready
// drop, until the receiver takes that word.
// Configuration (filter enable and filter code) is written through cfg_we,
// cfg_index and cfg_data; the user must write it only while no burst is in
// flight, which the block does not enforce. Reset clears the burst state,
// both filter registers and the valid flags; ready is high once reset ends.
module ook_remote_frame_decoder (
    input  logic                       clk,
    input  logic                       rst_n,
    orfd_pulse_if.sink                 pulse,
    orfd_frame_if.source               frame,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [orfd_pkg::CFG_W-1:0] cfg_data
);
    import orfd_pkg::*;

    logic              in_valid_reg;
    logic [NS_W-1:0]   in_ns_reg;
    logic              in_last_reg;
    logic              out_valid_reg;
    frame_result_t     out_res_reg;
    logic              filter_enable_reg;
    logic [CODE_W-1:0] filter_code_reg;

    logic              step;
    logic              take;
    frame_result_t     result;

    // The held pulse moves on unless it ends a burst and the output stalls.
    assign step        = in_valid_reg && (!in_last_reg || !out_valid_reg || frame.ready);
    assign pulse.ready = !in_valid_reg || step;
    assign take        = pulse.valid && pulse.ready;

    orfd_burst u_burst (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .low_time_ns   (in_ns_reg),
        .last_pulse    (in_last_reg),
        .filter_enable (filter_enable_reg),
        .filter_code   (filter_code_reg),
        .result        (result)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (pulse.ready)
        begin
            in_valid_reg <= pulse.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_ns_reg   <= pulse.low_time_ns;
            in_last_reg <= pulse.last_pulse;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (frame.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && in_last_reg)
        begin
            out_res_reg <= result;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_enable_reg <= 1'b0;
            filter_code_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FILTER_ENABLE: filter_enable_reg <= cfg_data[0];
                CFG_FILTER_CODE:   filter_code_reg   <= cfg_data[CODE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign frame.valid        = out_valid_reg;
    assign frame.status       = out_res_reg.status;
    assign frame.tx_code      = out_res_reg.tx_code;
    assign frame.group_flag   = out_res_reg.group_flag;
    assign frame.switch_on    = out_res_reg.switch_on;
    assign frame.chan_sel     = out_res_reg.chan_sel;
    assign frame.unit_sel     = out_res_reg.unit_sel;
    assign frame.filter_match = out_res_reg.filter_match;

endmodule

@@ tb/ook_remote_frame_decoder_tb.sv @@
`timescale 1ns / 1ps

module ook_remote_frame_decoder_tb;
    import orfd_pkg::*;

    // Gap thresholds in whole 250 us units, and the saturation point.
    localparam int SYNC_UNITS  = 10;
    localparam int ONE_UNITS   = 5;
    localparam int PAUSE_UNITS = 40;
    localparam int UNIT_CAP    = 255;

    localparam logic [NS_W-1:0] NS_MAX = 32'hFFFF_FFFF;

    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 12;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 400;

    typedef enum logic {ROW_GAP, ROW_BITS} row_kind_t;

    // One row drives either a single gap or a run of logical bits (two gaps each).
    // Where typed is set, the frame word is the given status with every field zero.
    typedef struct packed {
        row_kind_t       kind;
        logic [NS_W-1:0] value;
        logic [5:0]      nbits;
        logic            last;
        logic            typed;
        status_t         want;
    } stim_row_t;

    localparam int DIR_ROWS = 31;

    localparam stim_row_t DIRECTED [DIR_ROWS] = '{
        // Short first pulse, then a sync one unit short and a word ignored after it.
        '{ROW_GAP,  32'd0,                6'd0,  1'b1, 1'b1, ST_NO_SYNC},
        '{ROW_GAP,  SYNC_MIN_NS - 1,      6'd0,  1'b0, 1'b0, ST_OK},
        '{ROW_GAP,  NS_MAX,               6'd0,  1'b1, 1'b1, ST_NO_SYNC},
        // Burst ending on its sync pulse.
        '{ROW_GAP,  SYNC_MIN_NS,          6'd0,  1'b1, 1'b1, ST_SHORT},
        // Saturated sync, then a pair of ones.
        '{ROW_GAP,  NS_MAX,               6'd0,  1'b0, 1'b0, ST_OK},
        '{ROW_GAP,  32'd0,                6'd0,  1'b0, 1'b0, ST_OK},
        '{ROW_GAP,  ONE_MAX_NS - 1,       6'd0,  1'b1, 1'b1, ST_BAD_PAIR},
        // A pair of zeros, one of them saturated, then an ignored final word.
        '{ROW_GAP,  32'd3000000,          6'd0,  1'b0, 1'b0, ST_OK},
        '{ROW_GAP,  ONE_MAX_NS,           6'd0,  1'b0, 1'b0, ST_OK},
        '{ROW_GAP,  NS_MAX,               6'd0,  1'b0, 1'b0, ST_OK},
        '{ROW_GAP,  32'd0,                6'd0,  1'b1, 1'b1, ST_BAD_PAIR},
        // Burst ending in the middle of the data, half a pair held.
        '{ROW_GAP,  SYNC_MIN_NS,          6'd0,  1'b0, 1'b0, ST_OK},
        '{ROW_BITS, 32'h0000_0005,        6'd3,  1'b0, 1'b0, ST_OK},
        '{ROW_GAP,  32'd0,                6'd0,  1'b1, 1'b1, ST_SHORT},
        // All-ones frame closed by the shortest pause.
        '{ROW_GAP,  NS_MAX,               6'd0,  1'b0, 1'b0, ST_OK},
        '{ROW_BITS, 32'hFFFF_FFFF,        6'd32, 1'b0, 1'b0, ST_OK},
        '{ROW_GAP,  PAUSE_MIN_NS,         6'd0,  1'b1, 1'b0, ST_OK},
        // All-zeros frame, saturated pause, then ignored words.
        '{ROW_GAP,  SYNC_MIN_NS,          6'd0,  1'b0, 1'b0, ST_OK},
        '{ROW_BITS, 32'h0000_0000,        6'd32, 1'b0, 1'b0, ST_OK},
        '{ROW_GAP,  NS_MAX,               6'd0,  1'b0, 1'b0, ST_OK},
        '{ROW_GAP,  32'd0,                6'd0,  1'b0, 1'b0, ST_OK},
        '{ROW_GAP,  ONE_MAX_NS,           6'd0,  1'b1, 1'b0, ST_OK},
        // Burst ending on the last data bit, before any pause.
        '{ROW_GAP,  NS_MAX,               6'd0,  1'b0, 1'b0, ST_OK},
        '{ROW_BITS, 32'hA5C3_0F96,        6'd32, 1'b1, 1'b1, ST_NO_PAUSE},
        // Pause one unit short, then an ignored final word.
        '{ROW_GAP,  SYNC_MIN_NS,          6'd0,  1'b0, 1'b0, ST_OK},
        '{ROW_BITS, 32'h3C5A_96E1,        6'd32, 1'b0, 1'b0, ST_OK},
        '{ROW_GAP,  PAUSE_MIN_NS - 1,     6'd0,  1'b0, 1'b0, ST_OK},
        '{ROW_GAP,  NS_MAX,               6'd0,  1'b1, 1'b1, ST_NO_PAUSE},
        // Mixed frame: code, channel and unit fields non-zero, both flags zero.
        '{ROW_GAP,  32'd2600000,          6'd0,  1'b0, 1'b0, ST_OK},
        '{ROW_BITS, 32'h9E37_79B9,        6'd32, 1'b0, 1'b0, ST_OK},
        '{ROW_GAP,  32'h8000_0000,        6'd0,  1'b1, 1'b0, ST_OK}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [CFG_W-1:0] cfg_data;

    orfd_pulse_if pulse ();
    orfd_frame_if frame ();

    ook_remote_frame_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pulse     (pulse),
        .frame     (frame),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Decoder state as the block should hold it.
    logic [2:0]        burst_phase = PH_SYNC;
    logic [CNT_W-1:0]  pairs_done  = '0;
    logic              pair_open   = 1'b0;
    logic              held_phys   = 1'b0;
    logic [31:0]       frame_word  = '0;
    status_t           burst_error = ST_OK;
    logic              filt_en     = 1'b0;
    logic [CODE_W-1:0] filt_code   = '0;

    frame_result_t   frames_due[$];
    logic [NS_W-1:0] burst_gaps[$];

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int rx_hold_req  = 0;
    int fail_count   = 0;
    int pulses_sent  = 0;
    int frames_total = 0;
    int cycle_count  = 0;

    // Fold one pulse into the burst state; on a final pulse, build the frame word.
    task automatic decode_pulse(input logic [NS_W-1:0] ns, input logic last,
                                output logic produced, output frame_result_t res);
        logic [NS_W-1:0] units;
        logic            phys;
        units = ns / UNIT_NS;
        if (units > UNIT_CAP)
            units = UNIT_CAP;
        phys = (units < ONE_UNITS);
        case (burst_phase)
            PH_SYNC:
            begin
                if (units >= SYNC_UNITS)
                    burst_phase = PH_BITS;
                else
                begin
                    burst_error = ST_NO_SYNC;
                    burst_phase = PH_ERR;
                end
            end
            PH_BITS:
            begin
                if (!pair_open)
                begin
                    held_phys = phys;
                    pair_open = 1'b1;
                end
                else
                begin
                    pair_open = 1'b0;
                    if (held_phys == phys)
                    begin
                        burst_error = ST_BAD_PAIR;
                        burst_phase = PH_ERR;
                    end
                    else
                    begin
                        frame_word[pairs_done] = held_phys;
                        pairs_done = pairs_done + 1'b1;
                        if (pairs_done >= FRAME_BITS)
                            burst_phase = PH_PAUSE;
                    end
                end
            end
            PH_PAUSE:
            begin
                if (units >= PAUSE_UNITS)
                    burst_phase = PH_DONE;
                else
                begin
                    burst_error = ST_NO_PAUSE;
                    burst_phase = PH_ERR;
                end
            end
            default:
            begin
            end
        endcase

        res = '0;
        produced = last;
        if (last)
        begin
            case (burst_phase)
                PH_ERR:   res.status = burst_error;
                PH_DONE:  res.status = ST_OK;
                PH_PAUSE: res.status = ST_NO_PAUSE;
                default:  res.status = ST_SHORT;
            endcase
            if (res.status == ST_OK)
            begin
                res.tx_code      = frame_word[CODE_BITS-1:0];
                res.group_flag   = ~frame_word[CODE_BITS];
                res.switch_on    = ~frame_word[CODE_BITS+1];
                res.chan_sel     = frame_word[CODE_BITS+3:CODE_BITS+2];
                res.unit_sel     = frame_word[CODE_BITS+5:CODE_BITS+4];
                res.filter_match = !filt_en || (res.tx_code == filt_code);
            end
            burst_phase = PH_SYNC;
            pairs_done  = '0;
            pair_open   = 1'b0;
            held_phys   = 1'b0;
            frame_word  = '0;
            burst_error = ST_OK;
        end
    endtask

    // Random gap in [lo, hi], often close to one of the two ends.
    function automatic logic [NS_W-1:0] gap_ns(input logic [NS_W-1:0] lo,
                                               input logic [NS_W-1:0] hi);
        logic [NS_W-1:0] off;
        off = $urandom_range(2 * UNIT_NS, 0);
        if (off > hi - lo)
            off = hi - lo;
        case ($urandom_range(2, 0))
            0:       return $urandom_range(hi, lo);
            1:       return lo + off;
            default: return hi - off;
        endcase
    endfunction

    // Logical 1 is a short gap then a long one; logical 0 the other way round.
    function automatic void add_bits(input logic [31:0] bits, input int count);
        for (int i = 0; i < count; i++)
        begin
            if (bits[i])
            begin
                burst_gaps.push_back(gap_ns(0, ONE_MAX_NS - 1));
                burst_gaps.push_back(gap_ns(ONE_MAX_NS, NS_MAX));
            end
            else
            begin
                burst_gaps.push_back(gap_ns(ONE_MAX_NS, NS_MAX));
                burst_gaps.push_back(gap_ns(0, ONE_MAX_NS - 1));
            end
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Offer one pulse word, wait for it to be taken, and predict its effect.
    task automatic send_pulse(input logic [NS_W-1:0] ns, input logic last,
                              input logic typed, input status_t want);
        logic          produced;
        frame_result_t res;
        while ($urandom_range(99, 0) < src_idle_pct)
        begin
            pulse.valid <= 1'b0;
            @(posedge clk);
        end
        pulse.valid       <= 1'b1;
        pulse.low_time_ns <= ns;
        pulse.last_pulse  <= last;
        do
            @(posedge clk);
        while (pulse.ready !== 1'b1);

        // Words after an error or after the pause do not move the decoder on.
        if (last || (burst_phase != PH_DONE && burst_phase != PH_ERR))
            pulses_sent++;
        decode_pulse(ns, last, produced, res);
        if (produced)
        begin
            if (typed)
            begin
                res = '0;
                res.status = want;
            end
            frames_due.push_back(res);
            frames_total++;
        end
    endtask

    // Stop offering words and wait until every frame word has come out.
    task automatic drain_frames();
        pulse.valid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
    endtask

    // Filter registers are only written with no burst in flight.
    task automatic set_filter(input logic en, input logic [CODE_W-1:0] code);
        logic [CFG_W-1:0] en_word;
        drain_frames();
        repeat (SETTLE_CYCLES) @(posedge clk);
        // Only bit 0 of the enable write counts; the rest is noise.
        en_word    = CFG_W'($urandom);
        en_word[0] = en;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FILTER_ENABLE;
        cfg_data  <= en_word;
        @(posedge clk);
        cfg_index <= CFG_FILTER_CODE;
        cfg_data  <= code;
        @(posedge clk);
        cfg_we    <= 1'b0;
        filt_en   = en;
        filt_code = code;
    endtask

    // Mostly well-formed frames with random content; the rest broken or noise.
    task automatic send_burst();
        int          pick;
        logic [31:0] bits;
        pick = $urandom_range(99, 0);
        burst_gaps.delete();
        if (pick < 60)
        begin
            bits = $urandom;
            if ($urandom_range(99, 0) < 35)
                bits[CODE_BITS-1:0] = filt_code;
            burst_gaps.push_back(gap_ns(SYNC_MIN_NS, NS_MAX));
            add_bits(bits, FRAME_BITS);
            burst_gaps.push_back(gap_ns(PAUSE_MIN_NS, NS_MAX));
            repeat ($urandom_range(3, 0)) burst_gaps.push_back($urandom);
        end
        else if (pick < 68)
        begin
            burst_gaps.push_back(gap_ns(0, SYNC_MIN_NS - 1));
            repeat ($urandom_range(3, 0)) burst_gaps.push_back($urandom);
        end
        else if (pick < 78)
        begin
            burst_gaps.push_back(gap_ns(SYNC_MIN_NS, NS_MAX));
            add_bits($urandom, $urandom_range(FRAME_BITS - 1, 0));
            if ($urandom_range(1, 0))
            begin
                burst_gaps.push_back(gap_ns(0, ONE_MAX_NS - 1));
                burst_gaps.push_back(gap_ns(0, ONE_MAX_NS - 1));
            end
            else
            begin
                burst_gaps.push_back(gap_ns(ONE_MAX_NS, NS_MAX));
                burst_gaps.push_back(gap_ns(ONE_MAX_NS, NS_MAX));
            end
            repeat ($urandom_range(2, 0)) burst_gaps.push_back($urandom);
        end
        else if (pick < 86)
        begin
            burst_gaps.push_back(gap_ns(SYNC_MIN_NS, NS_MAX));
            add_bits($urandom, FRAME_BITS);
            if ($urandom_range(1, 0))
            begin
                burst_gaps.push_back(gap_ns(0, PAUSE_MIN_NS - 1));
                repeat ($urandom_range(2, 0)) burst_gaps.push_back($urandom);
            end
        end
        else if (pick < 94)
        begin
            burst_gaps.push_back(gap_ns(SYNC_MIN_NS, NS_MAX));
            add_bits($urandom, $urandom_range(FRAME_BITS - 1, 0));
            if ($urandom_range(1, 0))
                burst_gaps.push_back($urandom);
        end
        else
        begin
            repeat ($urandom_range(10, 1)) burst_gaps.push_back($urandom);
        end

        foreach (burst_gaps[i])
            send_pulse(burst_gaps[i], i == burst_gaps.size() - 1, 1'b0, ST_OK);
    endtask

    task automatic run_random(input int src_pct, input int snk_pct,
                              input int pulse_goal, input int frame_goal);
        int pulses_start;
        int frames_start;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        pulses_start = pulses_sent;
        frames_start = frames_total;
        while (pulses_sent - pulses_start < pulse_goal
               || frames_total - frames_start < frame_goal)
            send_burst();
    endtask

    // Frame receiver: checks each word taken and stalls at random or on request.
    initial
    begin
        int            hold_left;
        frame_result_t want;
        hold_left = 0;
        frame.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && frame.valid === 1'b1 && frame.ready === 1'b1)
            begin
                if (frames_due.size() == 0)
                begin
                    $error("frame word with no frame expected, status %0d", frame.status);
                    fail_count++;
                end
                else
                begin
                    want = frames_due.pop_front();
                    check_field("status", 32'(want.status), 32'(frame.status));
                    check_field("tx_code", 32'(want.tx_code), 32'(frame.tx_code));
                    check_field("group_flag", 32'(want.group_flag),
                                32'(frame.group_flag));
                    check_field("switch_on", 32'(want.switch_on), 32'(frame.switch_on));
                    check_field("chan_sel", 32'(want.chan_sel), 32'(frame.chan_sel));
                    check_field("unit_sel", 32'(want.unit_sel), 32'(frame.unit_sel));
                    check_field("filter_match", 32'(want.filter_match),
                                32'(frame.filter_match));
                end
            end
            if (rx_hold_req > 0)
            begin
                hold_left = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                frame.ready <= 1'b0;
            end
            else
                frame.ready <= ($urandom_range(99, 0) >= snk_idle_pct);
        end
    end

    // Watchdog.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // Main sequence.
    initial
    begin
        rst_n             <= 1'b0;
        pulse.valid       <= 1'b0;
        pulse.low_time_ns <= '0;
        pulse.last_pulse  <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_FILTER_ENABLE;
        cfg_data          <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table, filter off, no idling on the pulse side.
        set_filter(1'b0, '0);
        foreach (DIRECTED[r])
        begin
            if (DIRECTED[r].kind == ROW_GAP)
                send_pulse(DIRECTED[r].value, DIRECTED[r].last,
                           DIRECTED[r].typed, DIRECTED[r].want);
            else
            begin
                burst_gaps.delete();
                add_bits(DIRECTED[r].value, DIRECTED[r].nbits);
                foreach (burst_gaps[i])
                    send_pulse(burst_gaps[i],
                               DIRECTED[r].last && i == burst_gaps.size() - 1,
                               DIRECTED[r].typed, DIRECTED[r].want);
            end
        end

        // Random bursts under several filter settings and idling patterns.
        set_filter(1'b1, '1);
        run_random(38, 61, 230, 4);

        set_filter(1'b1, CODE_W'($urandom));
        run_random(61, 38, 230, 4);

        set_filter(1'b1, '0);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        // Hold the receiver off while one-word bursts pile up behind it.
        rx_hold_req = HOLD_CYCLES;
        repeat (12) send_pulse($urandom, 1'b1, 1'b0, ST_OK);
        drain_frames();
        run_random(0, 0, 230, 4);

        set_filter(1'b0, CODE_W'($urandom));
        run_random(0, 0, 90, 2);

        drain_frames();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/orfd_pkg.sv
hw/rtl/orfd_pulse_if.sv
hw/rtl/orfd_frame_if.sv
hw/rtl/orfd_burst.sv
hw/rtl/ook_remote_frame_decoder.sv
tb/ook_remote_frame_decoder_tb.sv
